>>> design/trvu_pkg.sv
// Shared types, widths, codes and a saturating increment helper for the ring traffic update block.
package trvu_pkg;

  localparam int VIDX_W    = 9;   // vehicle index and vehicle count fields
  localparam int LIM_W     = 11;  // speed limit register
  localparam int POS_OUT_W = 11;
  localparam int SPD_OUT_W = 11;
  localparam int GAP_OUT_W = 10;
  localparam int CTR_W     = 32;  // histogram entries and flux counter
  localparam int REG_IDX_W = 1;

  typedef enum logic [REG_IDX_W-1:0] {
    REG_SPEED_LIMIT   = 1'd0,
    REG_VEHICLE_COUNT = 1'd1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_SUB1
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_READ_AHEAD,
    ST_GAP,
    ST_GAP_FIX,
    ST_SPEED_INC,
    ST_SPEED_GAP,
    ST_SPEED_LIM,
    ST_MOVE,
    ST_WRAP,
    ST_WRAP_FIX,
    ST_WRITE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr_veh;
    logic wr_hist;
  } mem_ctl_t;

  function automatic logic [CTR_W-1:0] sat_inc(input logic [CTR_W-1:0] x);
    sat_inc = (&x) ? x : x + CTR_W'(1);
  endfunction

endpackage

>>> design/trvu_chan_if.sv
// Valid/ready channel interfaces for update requests and their results.
interface trvu_in_if import trvu_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [VIDX_W-1:0] vehicle_index;
  logic              measure;

  modport source (output valid, vehicle_index, measure, input ready);
  modport sink (input valid, vehicle_index, measure, output ready);
endinterface

interface trvu_out_if import trvu_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [POS_OUT_W-1:0] new_position;
  logic [SPD_OUT_W-1:0] new_speed;
  logic [GAP_OUT_W-1:0] gap_cells;
  logic                 wrapped;
  logic [CTR_W-1:0]     flux_total;
  logic [CTR_W-1:0]     gap_count;
  logic                 bad_index;

  modport source (output valid, new_position, new_speed, gap_cells, wrapped, flux_total,
                  gap_count, bad_index, input ready);
  modport sink (input valid, new_position, new_speed, gap_cells, wrapped, flux_total,
                gap_count, bad_index, output ready);
endinterface

>>> design/trvu_alu.sv
// Shared add/subtract unit with a borrow flag, reused by every gap, speed and position step.
module trvu_alu import trvu_pkg::*; #(
  parameter int W = 18
) (
  input  alu_op_t      op,
  input  logic [W-1:0] a,
  input  logic [W-1:0] b,
  output logic [W-1:0] result,
  output logic         neg
);

  logic [W-1:0] bx;
  logic         cin;
  logic [W:0]   wide;

  always_comb begin
    case (op)
      ALU_ADD: begin
        bx  = b;
        cin = 1'b0;
      end
      ALU_SUB: begin
        bx  = ~b;
        cin = 1'b1;
      end
      ALU_SUB1: begin
        bx  = ~b;
        cin = 1'b0;
      end
      default: begin
        bx  = b;
        cin = 1'b0;
      end
    endcase
    wide   = {1'b0, a} + {1'b0, bx} + (W+1)'(cin);
    result = wide[W-1:0];
    // With an inverted operand the carry out is high when no borrow occurred.
    neg    = (op != ALU_ADD) && !wide[W];
  end

endmodule

>>> design/trvu_mem.sv
// Position, speed and gap histogram memories with registered reads.
module trvu_mem import trvu_pkg::*; #(
  parameter int RING_CELLS   = 1024,
  parameter int MAX_VEHICLES = 256
) (
  input  logic                          clk,
  input  mem_ctl_t                      ctl,
  input  logic [$clog2(MAX_VEHICLES)-1:0] veh_addr,
  input  logic [$clog2(RING_CELLS+1)-1:0] pos_wdata,
  input  logic [$clog2(RING_CELLS)-1:0] spd_wdata,
  input  logic [$clog2(RING_CELLS)-1:0] hist_addr,
  input  logic [CTR_W-1:0]              hist_wdata,
  output logic [$clog2(RING_CELLS+1)-1:0] pos_rdata,
  output logic [$clog2(RING_CELLS)-1:0] spd_rdata,
  output logic [CTR_W-1:0]              hist_rdata
);

  localparam int PW = $clog2(RING_CELLS + 1);
  localparam int GW = $clog2(RING_CELLS);

  logic [PW-1:0]    positions [MAX_VEHICLES];
  logic [GW-1:0]    speeds [MAX_VEHICLES];
  logic [CTR_W-1:0] gap_histogram [RING_CELLS];

  always_ff @(posedge clk) begin
    if (ctl.wr_veh) begin
      positions[veh_addr] <= pos_wdata;
      speeds[veh_addr]    <= spd_wdata;
    end
    pos_rdata <= positions[veh_addr];
    spd_rdata <= speeds[veh_addr];
  end

  always_ff @(posedge clk) begin
    if (ctl.wr_hist) begin
      gap_histogram[hist_addr] <= hist_wdata;
    end
    hist_rdata <= gap_histogram[hist_addr];
  end

endmodule

>>> design/trvu_ctrl.sv
// Sequencer: clearing sweep, one update per request through the shared unit, result register.
module trvu_ctrl import trvu_pkg::*; #(
  parameter int RING_CELLS   = 1024,
  parameter int MAX_VEHICLES = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [LIM_W-1:0]  speed_limit,
  input  logic [VIDX_W-1:0] vehicle_total,
  trvu_in_if.sink           in_ch,
  trvu_out_if.source        out_ch
);

  localparam int PW    = $clog2(RING_CELLS + 1);
  localparam int GW    = $clog2(RING_CELLS);
  localparam int VW    = $clog2(MAX_VEHICLES);
  localparam int AW    = ((PW > LIM_W) ? PW : LIM_W) + 1;
  localparam int SWEEP = (RING_CELLS > MAX_VEHICLES) ? RING_CELLS : MAX_VEHICLES;
  localparam int CW    = $clog2(SWEEP);

  state_t state, state_next;

  logic [CW-1:0]     clr_cnt;
  logic [PW-1:0]     seed;
  logic [VIDX_W-1:0] idx;
  logic              measure;
  logic              bad;
  logic [PW-1:0]     ps;
  logic [GW-1:0]     spd;
  logic [AW-1:0]     acc;
  logic              neg_hold;
  logic [GW-1:0]     gap;
  logic [GW-1:0]     vel;
  logic              wrap;
  logic [PW-1:0]     np;
  logic [CTR_W-1:0]  hcnt;
  logic [CTR_W-1:0]  flux;

  logic [POS_OUT_W-1:0] o_position;
  logic [SPD_OUT_W-1:0] o_speed;
  logic [GAP_OUT_W-1:0] o_gap;
  logic                 o_wrapped;
  logic [CTR_W-1:0]     o_flux;
  logic [CTR_W-1:0]     o_count;
  logic                 o_bad;
  logic                 o_valid;

  logic              accept;
  logic              load_out;
  logic              idx_bad;
  logic [VW-1:0]     self_addr;
  logic [VW-1:0]     ahead_addr;
  logic [CTR_W-1:0]  hist_new;

  alu_op_t       alu_op;
  logic [AW-1:0] alu_a;
  logic [AW-1:0] alu_b;
  logic [AW-1:0] alu_result;
  logic          alu_neg;

  mem_ctl_t         mem_ctl;
  logic [VW-1:0]    veh_addr;
  logic [PW-1:0]    pos_wdata;
  logic [GW-1:0]    spd_wdata;
  logic [GW-1:0]    hist_addr;
  logic [CTR_W-1:0] hist_wdata;
  logic [PW-1:0]    pos_rdata;
  logic [GW-1:0]    spd_rdata;
  logic [CTR_W-1:0] hist_rdata;

  trvu_alu #(.W(AW)) u_alu (
    .op     (alu_op),
    .a      (alu_a),
    .b      (alu_b),
    .result (alu_result),
    .neg    (alu_neg)
  );

  trvu_mem #(.RING_CELLS(RING_CELLS), .MAX_VEHICLES(MAX_VEHICLES)) u_mem (
    .clk        (clk),
    .ctl        (mem_ctl),
    .veh_addr   (veh_addr),
    .pos_wdata  (pos_wdata),
    .spd_wdata  (spd_wdata),
    .hist_addr  (hist_addr),
    .hist_wdata (hist_wdata),
    .pos_rdata  (pos_rdata),
    .spd_rdata  (spd_rdata),
    .hist_rdata (hist_rdata)
  );

  assign accept     = in_ch.valid && in_ch.ready;
  assign load_out   = (state == ST_DONE) && (!o_valid || out_ch.ready);
  assign idx_bad    = (idx == '0) || (idx > vehicle_total);
  assign self_addr  = VW'(idx - VIDX_W'(1));
  // The last vehicle follows the first one around the ring.
  assign ahead_addr = (idx == vehicle_total) ? '0 : VW'(idx);
  assign hist_new   = measure ? sat_inc(hcnt) : hcnt;

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:      if (clr_cnt == CW'(SWEEP - 1)) state_next = ST_IDLE;
      ST_IDLE:       if (in_ch.valid) state_next = ST_CHECK;
      ST_CHECK:      state_next = idx_bad ? ST_DONE : ST_READ_AHEAD;
      ST_READ_AHEAD: state_next = ST_GAP;
      ST_GAP:        state_next = ST_GAP_FIX;
      ST_GAP_FIX:    state_next = ST_SPEED_INC;
      ST_SPEED_INC:  state_next = ST_SPEED_GAP;
      ST_SPEED_GAP:  state_next = ST_SPEED_LIM;
      ST_SPEED_LIM:  state_next = ST_MOVE;
      ST_MOVE:       state_next = ST_WRAP;
      ST_WRAP:       state_next = ST_WRAP_FIX;
      ST_WRAP_FIX:   state_next = ST_WRITE;
      ST_WRITE:      state_next = ST_DONE;
      ST_DONE:       if (!o_valid || out_ch.ready) state_next = ST_IDLE;
      default:       state_next = ST_CLEAR;
    endcase
  end

  // Outputs of the sequencer: handshake, memory controls and shared unit operands.
  always_comb begin
    in_ch.ready     = (state == ST_IDLE);
    mem_ctl.wr_veh  = 1'b0;
    mem_ctl.wr_hist = 1'b0;
    veh_addr        = self_addr;
    hist_addr       = gap;
    pos_wdata       = np;
    spd_wdata       = vel;
    hist_wdata      = hist_new;
    alu_op          = ALU_ADD;
    alu_a           = acc;
    alu_b           = '0;
    case (state)
      ST_CLEAR: begin
        mem_ctl.wr_veh  = (32'(clr_cnt) < MAX_VEHICLES);
        mem_ctl.wr_hist = (32'(clr_cnt) < RING_CELLS);
        veh_addr        = clr_cnt[VW-1:0];
        hist_addr       = clr_cnt[GW-1:0];
        pos_wdata       = seed;
        spd_wdata       = '0;
        hist_wdata      = '0;
      end
      ST_READ_AHEAD: veh_addr = ahead_addr;
      ST_GAP: begin
        alu_op = ALU_SUB1;
        alu_a  = AW'(pos_rdata);
        alu_b  = AW'(ps);
      end
      ST_GAP_FIX: begin
        alu_b = AW'(RING_CELLS);
      end
      ST_SPEED_INC: begin
        alu_a = AW'(spd);
        alu_b = AW'(1);
      end
      ST_SPEED_GAP: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(gap);
        alu_b  = acc;
      end
      ST_SPEED_LIM: begin
        alu_op = ALU_SUB;
        alu_a  = AW'(speed_limit);
        alu_b  = acc;
      end
      ST_MOVE: begin
        alu_a = AW'(ps);
        alu_b = AW'(vel);
      end
      ST_WRAP: begin
        alu_op = ALU_SUB1;
        alu_b  = AW'(RING_CELLS);
      end
      ST_WRAP_FIX: begin
        alu_op = ALU_SUB;
        alu_b  = AW'(RING_CELLS);
      end
      ST_WRITE: begin
        mem_ctl.wr_veh  = 1'b1;
        mem_ctl.wr_hist = measure;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      seed    <= PW'(1);
      flux    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + CW'(1);
        seed    <= (seed == PW'(RING_CELLS)) ? PW'(1) : seed + PW'(1);
      end
      if ((state == ST_WRITE) && measure && wrap) begin
        flux <= sat_inc(flux);
      end
    end
  end

  // Datapath registers, loaded step by step from the request, the memories and the shared unit.
  always_ff @(posedge clk) begin
    if (accept) begin
      idx     <= in_ch.vehicle_index;
      measure <= in_ch.measure;
    end
    case (state)
      ST_CHECK: bad <= idx_bad;
      ST_READ_AHEAD: begin
        ps  <= pos_rdata;
        spd <= spd_rdata;
      end
      ST_GAP: begin
        acc      <= alu_result;
        neg_hold <= alu_neg;
      end
      // A leader at or behind this vehicle is ahead across the ring end.
      ST_GAP_FIX:   gap <= GW'(neg_hold ? alu_result : acc);
      ST_SPEED_INC: acc <= alu_result;
      ST_SPEED_GAP: begin
        acc  <= alu_neg ? AW'(gap) : acc;
        hcnt <= hist_rdata;
      end
      ST_SPEED_LIM: vel <= GW'(alu_neg ? AW'(speed_limit) : acc);
      ST_MOVE:      acc <= alu_result;
      ST_WRAP:      wrap <= !alu_neg;
      ST_WRAP_FIX:  np <= PW'(wrap ? alu_result : acc);
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (load_out) begin
      o_valid <= 1'b1;
    end else if (out_ch.ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      o_bad  <= bad;
      o_flux <= flux;
      if (bad) begin
        o_position <= '0;
        o_speed    <= '0;
        o_gap      <= '0;
        o_wrapped  <= 1'b0;
        o_count    <= '0;
      end else begin
        o_position <= POS_OUT_W'(np);
        o_speed    <= SPD_OUT_W'(vel);
        o_gap      <= GAP_OUT_W'(gap);
        o_wrapped  <= wrap;
        o_count    <= hist_new;
      end
    end
  end

  assign out_ch.valid        = o_valid;
  assign out_ch.new_position = o_position;
  assign out_ch.new_speed    = o_speed;
  assign out_ch.gap_cells    = o_gap;
  assign out_ch.wrapped      = o_wrapped;
  assign out_ch.flux_total   = o_flux;
  assign out_ch.gap_count    = o_count;
  assign out_ch.bad_index    = o_bad;

endmodule

>>> design/traffic_ring_vehicle_update.sv
// Top level of the ring traffic vehicle update block: configuration registers and sequencer.
//
// Each request updates one vehicle on a single-lane ring of RING_CELLS cells: it finds the
// gap to the vehicle ahead, sets the speed to the smallest of the speed limit, the gap and
// the old speed plus one, moves the vehicle and, when measure is set, counts the gap in a
// saturating histogram and a ring-end crossing in a saturating flux counter. All arithmetic
// runs through one shared add/subtract unit under a sequencer, and positions, speeds and the
// histogram sit in single-port memories, so a valid request passes the check, read-ahead,
// gap, gap fix, speed increment, speed gap, speed limit, move, wrap, wrap fix and write
// states before its result is registered; a rejected index goes from check to done. No
// request is taken before the last result is registered, but the block accepts the next one
// while a result still waits at the output. After reset a clearing pass over max(RING_CELLS,
// MAX_VEHICLES) addresses loads the starting positions and zeroes speeds and histogram;
// requests are held off during it, configuration writes are taken at any time.
module traffic_ring_vehicle_update import trvu_pkg::*; #(
  parameter int RING_CELLS   = 1024,
  parameter int MAX_VEHICLES = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LIM_W-1:0]     cfg_data,
  trvu_in_if.sink              in_ch,
  trvu_out_if.source           out_ch
);

  logic [LIM_W-1:0]  speed_limit;
  logic [VIDX_W-1:0] vehicle_count;
  logic [VIDX_W-1:0] vehicle_total;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_limit   <= LIM_W'(1);
      vehicle_count <= VIDX_W'(1);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SPEED_LIMIT:   speed_limit <= cfg_data;
        REG_VEHICLE_COUNT: vehicle_count <= cfg_data[VIDX_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // A count of zero means one vehicle; counts beyond the storage are clamped.
  always_comb begin
    if (vehicle_count == '0) begin
      vehicle_total = VIDX_W'(1);
    end else if (32'(vehicle_count) > MAX_VEHICLES) begin
      vehicle_total = VIDX_W'(MAX_VEHICLES);
    end else begin
      vehicle_total = vehicle_count;
    end
  end

  trvu_ctrl #(.RING_CELLS(RING_CELLS), .MAX_VEHICLES(MAX_VEHICLES)) u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .speed_limit   (speed_limit),
    .vehicle_total (vehicle_total),
    .in_ch         (in_ch),
    .out_ch        (out_ch)
  );

endmodule
